// ----- design/fmv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmv_pkg
// Shared types and constants of the forgetting mean and variance estimator.
// ----------------------------------------------------------------------------
package fmv_pkg;

  localparam int SampleW = 16;
  localparam int FracBits = 16;
  localparam int LambdaW = 17;
  localparam int MeanW = 32;
  localparam int VarW = 48;
  localparam int WordW = 32;
  localparam int OpW = 64;
  localparam int ProdW = 128;

  localparam logic [LambdaW-1:0] LambdaReset = LambdaW'(65536);
  localparam logic [WordW-1:0] OneFx = WordW'(1) << FracBits;
  localparam logic [WordW-1:0] Q31One = WordW'(1) << 31;
  localparam logic [VarW-1:0] VarMax = '1;

  typedef enum logic [3:0] {
    S_IDLE, S_W, S_B, S_A, S_AA, S_AAU, S_BB, S_V,
    S_LV, S_R, S_T1, S_DD, S_T2M, S_T2, S_C, S_DONE
  } seq_state_e;

  typedef struct packed {
    logic [WordW-1:0] v_term;
    logic [WordW-1:0] u_term;
    logic [WordW-1:0] weight_sum;
    logic [VarW-1:0]  variance;
    logic [MeanW-1:0] mean;
  } result_t;

endpackage

// ----- design/fmv_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmv_mul
// Shared 64 x 64 multiplier, one 32 x 32 partial product per cycle.
// ----------------------------------------------------------------------------
module fmv_mul
  import fmv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [OpW-1:0]   a_i,
  input  logic [OpW-1:0]   b_i,
  output logic             done_o,
  output logic [ProdW-1:0] prod_o
);

  logic [OpW-1:0]   a_q, b_q;
  logic [OpW-1:0]   pp_q;
  logic [1:0]       sh_q;
  logic [ProdW-1:0] acc_q;
  logic [2:0]       step_q;
  logic             busy_q, done_q;
  logic [31:0]      pa, pb;
  logic [ProdW-1:0] pp_shift;

  assign pa = step_q[0] ? a_q[63:32] : a_q[31:0];
  assign pb = step_q[1] ? b_q[63:32] : b_q[31:0];
  assign pp_shift = {64'd0, pp_q} << {sh_q, 5'd0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (step_q != 3'd4) begin
        pp_q <= pa * pb;
        sh_q <= 2'(step_q[0]) + 2'(step_q[1]);
      end
      if (step_q != 3'd0) begin
        acc_q <= acc_q + pp_shift;
      end
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ----- design/fmv_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmv_div
// Shared restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module fmv_div
  import fmv_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [OpW-1:0]   num_i,
  input  logic [WordW-1:0] den_i,
  output logic             done_o,
  output logic [OpW-1:0]   quot_o
);

  logic [OpW-1:0]   q_q;
  logic [WordW-1:0] rem_q, den_q;
  logic [5:0]       cnt_q;
  logic             busy_q, done_q;
  logic [WordW:0]   trial, rem_n;
  logic             ge;

  assign trial = {rem_q, q_q[OpW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_n = ge ? trial - {1'b0, den_q} : trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      q_q   <= {q_q[OpW-2:0], ge};
      rem_q <= rem_n[WordW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = q_q;

endmodule

// ----- design/fmv_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmv_core
// Sequencer and estimator state; drives the shared multiplier and divider.
// ----------------------------------------------------------------------------
module fmv_core
  import fmv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [LambdaW-1:0] lambda_i,
  input  logic               start_i,
  input  logic               restart_i,
  input  logic [SampleW-1:0] sample_i,
  output logic               idle_o,
  output logic               done_o,
  output result_t            res_o
);

  seq_state_e state_q, state_d;
  logic pend_q;

  logic [MeanW-1:0]   mean_q;
  logic [VarW-1:0]    var_q;
  logic [WordW-1:0]   w_q, u_q, v_q;
  logic [SampleW-1:0] sample_q;

  logic [WordW-1:0] wn_q, b_q, a_q, aa_q, tmp_q, un_q, vn_q;
  logic [48:0]      lv_q;
  logic [OpW-1:0]   r_q, sq_q, t2n_q;
  logic [VarW-1:0]  t1_q;

  logic             mul_sel, div_sel, mul_start, div_start, mul_done, div_done;
  logic [OpW-1:0]   mul_a, mul_b, div_n, quot;
  logic [WordW-1:0] div_d;
  logic [ProdW-1:0] prod;

  logic signed [33:0] d;
  logic [32:0]        dd;
  logic [33:0]        w_sum;
  logic [WordW:0]     u_sum;
  logic [VarW:0]      var_sum;
  logic [VarW-1:0]    t2;
  logic [32:0]        corr;
  logic signed [34:0] m_new;
  logic [MeanW-1:0]   m_sat;
  logic               upd_var;

  assign d  = 34'(signed'(mean_q)) - 34'(signed'({sample_q, 16'd0}));
  assign dd = d[33] ? 33'(-d) : 33'(d);

  assign w_sum   = 34'(prod[48:16]) + 34'(OneFx);
  assign u_sum   = 33'(tmp_q) + 33'(prod[62:31]);
  assign t2      = (|quot[63:48]) ? VarMax : quot[47:0];
  assign var_sum = 49'(t1_q) + 49'(t2);
  assign corr    = prod[63:31];
  assign m_new   = d[33] ? 35'(signed'(mean_q)) + 35'(corr)
                         : 35'(signed'(mean_q)) - 35'(corr);
  assign m_sat   = (m_new[34:31] == 4'b0000 || m_new[34:31] == 4'b1111) ? m_new[31:0]
                 : (m_new[34] ? 32'h8000_0000 : 32'h7fff_ffff);
  assign upd_var = (wn_q > OneFx) && (vn_q != '0);

  always_comb begin
    state_d = state_q;
    mul_sel = 1'b0;
    div_sel = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_n   = '0;
    div_d   = wn_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = restart_i ? S_DONE : S_W;
        end
      end
      S_W: begin
        mul_sel = 1'b1;
        mul_a   = 64'(lambda_i);
        mul_b   = 64'(w_q);
        if (mul_done) state_d = S_B;
      end
      S_B: begin
        div_sel = 1'b1;
        div_n   = 64'(1) << (31 + FracBits);
        if (div_done) state_d = S_A;
      end
      S_A: begin
        div_sel = 1'b1;
        div_n   = {1'b0, wn_q - OneFx, 31'd0};
        if (div_done) state_d = S_AA;
      end
      S_AA: begin
        mul_sel = 1'b1;
        mul_a   = 64'(a_q);
        mul_b   = 64'(a_q);
        if (mul_done) state_d = S_AAU;
      end
      S_AAU: begin
        mul_sel = 1'b1;
        mul_a   = 64'(aa_q);
        mul_b   = 64'(u_q);
        if (mul_done) state_d = S_BB;
      end
      S_BB: begin
        mul_sel = 1'b1;
        mul_a   = 64'(b_q);
        mul_b   = 64'(b_q);
        if (mul_done) state_d = S_V;
      end
      S_V: begin
        mul_sel = 1'b1;
        mul_a   = 64'(wn_q);
        mul_b   = 64'(Q31One - un_q);
        if (mul_done) state_d = S_LV;
      end
      S_LV: begin
        if (!upd_var) begin
          state_d = S_C;
        end else begin
          mul_sel = 1'b1;
          mul_a   = 64'(lambda_i);
          mul_b   = 64'(v_q);
          if (mul_done) state_d = S_R;
        end
      end
      S_R: begin
        div_sel = 1'b1;
        div_n   = 64'(lv_q);
        div_d   = vn_q;
        if (div_done) state_d = S_T1;
      end
      S_T1: begin
        mul_sel = 1'b1;
        mul_a   = 64'(var_q);
        mul_b   = r_q;
        if (mul_done) state_d = S_DD;
      end
      S_DD: begin
        mul_sel = 1'b1;
        mul_a   = 64'(dd);
        mul_b   = 64'(dd);
        if (mul_done) state_d = S_T2M;
      end
      S_T2M: begin
        mul_sel = 1'b1;
        mul_a   = sq_q;
        mul_b   = 64'(a_q);
        if (mul_done) state_d = S_T2;
      end
      S_T2: begin
        div_sel = 1'b1;
        div_n   = t2n_q;
        div_d   = vn_q;
        if (div_done) state_d = S_C;
      end
      S_C: begin
        mul_sel = 1'b1;
        mul_a   = 64'(dd);
        mul_b   = 64'(b_q);
        if (mul_done) state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign mul_start = mul_sel && !pend_q;
  assign div_start = div_sel && !pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pend_q  <= 1'b0;
      mean_q  <= '0;
      var_q   <= '0;
      w_q     <= '0;
      u_q     <= '0;
      v_q     <= '0;
    end else begin
      state_q <= state_d;
      if (mul_done || div_done) begin
        pend_q <= 1'b0;
      end else if (mul_start || div_start) begin
        pend_q <= 1'b1;
      end
      if (state_q == S_IDLE && start_i && restart_i) begin
        mean_q <= '0;
        var_q  <= '0;
        w_q    <= '0;
        u_q    <= '0;
        v_q    <= '0;
      end
      if (state_q == S_T2 && div_done) begin
        var_q <= var_sum[VarW] ? VarMax : var_sum[VarW-1:0];
      end
      if (state_q == S_C && mul_done) begin
        mean_q <= m_sat;
        w_q    <= wn_q;
        u_q    <= un_q;
        v_q    <= vn_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) sample_q <= sample_i;
    if (mul_done) begin
      unique case (state_q)
        S_W:   wn_q  <= w_sum[33:32] != 2'd0 ? '1 : w_sum[31:0];
        S_AA:  aa_q  <= prod[62:31];
        S_AAU: tmp_q <= prod[62:31];
        S_BB:  un_q  <= u_sum > 33'(Q31One) ? Q31One : u_sum[31:0];
        S_V:   vn_q  <= prod[62:31];
        S_LV:  lv_q  <= prod[48:0];
        S_T1:  t1_q  <= (|prod[127:64]) ? VarMax : prod[63:16];
        S_DD:  sq_q  <= (|prod[127:64]) ? '1 : prod[63:0];
        S_T2M: t2n_q <= prod[94:31];
        default: ;
      endcase
    end
    if (div_done) begin
      unique case (state_q)
        S_B:   b_q <= quot[31:0];
        S_A:   a_q <= quot[31:0];
        S_R:   r_q <= quot;
        default: ;
      endcase
    end
  end

  fmv_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  fmv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_n),
    .den_i   (div_d),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign idle_o = (state_q == S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign res_o  = '{v_term: v_q, u_term: u_q, weight_sum: w_q, variance: var_q,
                    mean: mean_q};

endmodule

// ----- design/forgetting_mean_variance.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// forgetting_mean_variance
// Exponentially forgotten mean and variance estimator, fixed point.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one request: tuser is the restart flag, tdata the signed
//   sample. m_axis returns the state after each request: mean, variance,
//   weight sum, u term and v term packed into tdata.
//   cfg_* writes lambda (Q1.16, 65536 = no forgetting); write only when idle.
// sequencing:
//   a restart request only clears the estimator state. when the variance is
//   updated, a sample request makes ten passes of the shared multiplier and
//   four passes of the one-bit restoring divider. one request at a time.
// reset:
//   all estimator state clears to zero and lambda returns to 65536.
// stall:
//   the result waits in the output register; s_axis_tready stays low until
//   it has been taken.
// ----------------------------------------------------------------------------
module forgetting_mean_variance
  import fmv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,   // sample
  input  logic               s_axis_tuser,   // req_type
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [175:0]       m_axis_tdata,   // mean, variance, weight_sum, u_term, v_term
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [LambdaW-1:0] cfg_data
);

  logic [LambdaW-1:0] lambda_q;
  logic               out_valid_q;
  result_t            out_q, res;
  logic               idle, done, start;

  assign s_axis_tready = idle && !out_valid_q;
  assign start         = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lambda_q    <= LambdaReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid) lambda_q <= cfg_data;
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) out_q <= res;
  end

  fmv_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .lambda_i  (lambda_q),
    .start_i   (start),
    .restart_i (s_axis_tuser),
    .sample_i  (s_axis_tdata[SampleW-1:0]),
    .idle_o    (idle),
    .done_o    (done),
    .res_o     (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ----- design/fmv_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fmv_checker
// Port-level checks of the estimator, bound to the top level.
// ----------------------------------------------------------------------------
module fmv_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [175:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while busy");

  a_no_req_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("request taken while result pending");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)
    else $error("extra result");

  a_u_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[143] && (|m_axis_tdata[142:112])))
    else $error("u term above one");

endmodule

bind forgetting_mean_variance fmv_checker u_fmv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
